// ===== src/modem_status_and_payload_parser_assert.svh =====
// Assertion macros shared by the modem parser RTL.
// Each macro checks an implication on the rising clock edge while out of reset.
`ifndef MODEM_STATUS_AND_PAYLOAD_PARSER_ASSERT_SVH
`define MODEM_STATUS_AND_PAYLOAD_PARSER_ASSERT_SVH

// Same-cycle implication.
`define MSP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define MSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/msp_pkg.sv =====
// Shared types, codes and keyword constants of the modem status and payload parser.
// No dependencies; the top level imports this package.
package msp_pkg;

	localparam int STORE_DEPTH_DEF = 256;

	localparam logic [1:0] MODE_RX      = 2'd0;
	localparam logic [1:0] MODE_READ    = 2'd1;
	localparam logic [1:0] MODE_RELEASE = 2'd2;
	localparam logic [1:0] MODE_ACK     = 2'd3;

	// Keywords, first character in the most significant byte.
	localparam int LEN_GOT_IP  = 11;
	localparam int LEN_DISC    = 15;
	localparam int LEN_CONNECT = 7;
	localparam int LEN_CLOSED  = 6;
	localparam int LEN_START   = 9;
	localparam int LEN_STOP    = 8;

	localparam logic [8*LEN_GOT_IP-1:0]  KW_GOT_IP  = "WIFI GOT IP";
	localparam logic [8*LEN_DISC-1:0]    KW_DISC    = "WIFI DISCONNECT";
	localparam logic [8*LEN_CONNECT-1:0] KW_CONNECT = "CONNECT";
	localparam logic [8*LEN_CLOSED-1:0]  KW_CLOSED  = "CLOSED";
	localparam logic [8*LEN_START-1:0]   KW_START   = "JSONStart";
	localparam logic [8*LEN_STOP-1:0]    KW_STOP    = "JSONStop";

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] rx_byte;
		logic [7:0] read_index;
	} cmd_t;

	typedef struct packed {
		logic       echo_valid;
		logic [7:0] echo_byte;
		logic       wifi_up;
		logic       socket_up;
		logic       status_changed;
		logic       payload_ready;
		logic [8:0] payload_length;
		logic [7:0] read_data;
		logic       overflow;
	} status_t;

endpackage

// ===== src/msp_stream_if.sv =====
// Valid/ready channel carrying one item of type T.
// Used for the command and status channels of the modem parser; depends on nothing.
interface msp_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/msp_matcher.sv =====
// Naive keyword matcher: one position register, one received byte compared per step.
// Keyword and length come from msp_pkg through parameters of the top level.
module msp_matcher #(
	parameter int LEN = 8,
	parameter logic [8*LEN-1:0] KW = '0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] ch,
	output logic       hit
);
	localparam int PW = $clog2(LEN);

	logic [7:0]    chars [LEN];
	logic [PW-1:0] pos_q;
	logic [PW-1:0] pos_d;
	logic          same;

	for (genvar i = 0; i < LEN; i++) begin : g_chars
		assign chars[i] = KW[8*(LEN-1-i) +: 8];
	end

	assign same = (ch == chars[pos_q]);
	assign hit  = en && same && (pos_q == PW'(LEN - 1));

	// On a mismatch the byte may still start a fresh match.
	always_comb begin
		if (same && (pos_q != PW'(LEN - 1))) begin
			pos_d = PW'(pos_q + 1'b1);
		end else if (!same && (ch == chars[0])) begin
			pos_d = PW'(1);
		end else begin
			pos_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (en) begin
			pos_q <= pos_d;
		end
	end
endmodule

// ===== src/msp_store.sv =====
// Payload store: one write port and one registered read port.
// Depth comes from the top level; contents are not reset.
module msp_store #(
	parameter int DEPTH = 256,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== src/modem_status_and_payload_parser.sv =====
// Top level of the modem status and payload parser.
// Uses msp_pkg, msp_stream_if, msp_matcher, msp_store and the assertion macro header.
`include "modem_status_and_payload_parser_assert.svh"

// The block takes one command item per clock cycle while the status side keeps
// taking items, and returns exactly one status item for each, registered in the cycle
// after it is accepted; the status register frees up as it is taken, so items flow
// back to back. A received byte runs the enabled keyword matchers in parallel, a
// payload read goes to the store's registered read port, and the status item shows
// the flags after that item's update. The store needs no clearing after reset; reads
// at or beyond the payload length, or with no payload ready, return zero.
module modem_status_and_payload_parser #(
	parameter int STORE_DEPTH = msp_pkg::STORE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	msp_stream_if.sink   cmd,
	msp_stream_if.source status
);
	import msp_pkg::*;

	localparam int AW   = $clog2(STORE_DEPTH);
	localparam int CW   = $clog2(STORE_DEPTH + 1);
	localparam int CMPW = (CW > 8) ? CW : 8;

	cmd_t          c;
	logic          accept;
	logic          is_rx;
	logic          scan;
	logic          cap;
	logic          room;

	logic          start_hit, got_hit, disc_hit, conn_hit, closed_hit, stop_hit;
	logic          link_d, sock_mid, sock_d;

	logic          link_q, sock_q, change_q, capturing_q, ready_q, overflow_q;
	logic [CW-1:0] wc_q;
	logic [CW-1:0] wc_inc;
	logic [CW-1:0] captured_len_q;
	logic [CW-1:0] captured_val;

	logic          rd_en;
	logic [7:0]    rd_data;
	logic          rd_sel_q;
	logic          out_valid_q;
	status_t       status_q;

	assign c      = cmd.data;
	assign accept = cmd.valid && cmd.ready;
	assign cmd.ready = !out_valid_q || status.ready;

	assign is_rx = accept && (c.mode == MODE_RX);
	assign scan  = is_rx && !capturing_q;
	assign cap   = is_rx && capturing_q && !ready_q;
	assign room  = (wc_q < CW'(STORE_DEPTH));

	msp_matcher #(.LEN(LEN_START), .KW(KW_START)) u_start (
		.clk(clk), .arst_n(arst_n), .en(scan), .ch(c.rx_byte), .hit(start_hit)
	);
	msp_matcher #(.LEN(LEN_GOT_IP), .KW(KW_GOT_IP)) u_got_ip (
		.clk(clk), .arst_n(arst_n), .en(scan && !link_q), .ch(c.rx_byte), .hit(got_hit)
	);
	msp_matcher #(.LEN(LEN_DISC), .KW(KW_DISC)) u_disc (
		.clk(clk), .arst_n(arst_n), .en(scan && link_q), .ch(c.rx_byte), .hit(disc_hit)
	);

	// The socket matchers see the link state as just updated by this byte.
	assign link_d   = got_hit ? 1'b1 : (disc_hit ? 1'b0 : link_q);
	assign sock_mid = disc_hit ? 1'b0 : sock_q;

	msp_matcher #(.LEN(LEN_CONNECT), .KW(KW_CONNECT)) u_connect (
		.clk(clk), .arst_n(arst_n), .en(scan && link_d && !sock_mid),
		.ch(c.rx_byte), .hit(conn_hit)
	);
	msp_matcher #(.LEN(LEN_CLOSED), .KW(KW_CLOSED)) u_closed (
		.clk(clk), .arst_n(arst_n), .en(scan && link_d && sock_mid),
		.ch(c.rx_byte), .hit(closed_hit)
	);
	msp_matcher #(.LEN(LEN_STOP), .KW(KW_STOP)) u_stop (
		.clk(clk), .arst_n(arst_n), .en(cap), .ch(c.rx_byte), .hit(stop_hit)
	);

	assign sock_d = conn_hit ? 1'b1 : (closed_hit ? 1'b0 : sock_mid);

	// Count including the byte stored this cycle; the stop keyword and the byte just
	// ahead of it are dropped from the length.
	assign wc_inc       = room ? CW'(wc_q + 1'b1) : wc_q;
	assign captured_val = (wc_inc > CW'(9)) ? CW'(wc_inc - CW'(9)) : '0;

	assign rd_en = accept && (c.mode == MODE_READ) && ready_q
		&& (CMPW'(c.read_index) < CMPW'(captured_len_q))
		&& (CMPW'(c.read_index) < CMPW'(STORE_DEPTH));

	msp_store #(.DEPTH(STORE_DEPTH), .AW(AW)) u_store (
		.clk(clk),
		.we(cap && room),
		.waddr(wc_q[AW-1:0]),
		.wdata(c.rx_byte),
		.re(rd_en),
		.raddr(AW'(c.read_index)),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q         <= 1'b0;
			sock_q         <= 1'b0;
			change_q       <= 1'b1;
			capturing_q    <= 1'b0;
			ready_q        <= 1'b0;
			overflow_q     <= 1'b0;
			wc_q           <= '0;
			captured_len_q <= '0;
		end else if (accept) begin
			case (c.mode)
				MODE_RX: begin
					link_q <= link_d;
					sock_q <= sock_d;
					if (got_hit || disc_hit || conn_hit || closed_hit) begin
						change_q <= 1'b1;
					end
					if (start_hit) begin
						capturing_q <= 1'b1;
					end
					if (cap) begin
						if (!room) begin
							overflow_q <= 1'b1;
						end
						if (stop_hit) begin
							capturing_q    <= 1'b0;
							ready_q        <= 1'b1;
							captured_len_q <= captured_val;
							wc_q           <= '0;
						end else begin
							wc_q <= wc_inc;
						end
					end
				end
				MODE_RELEASE: begin
					ready_q        <= 1'b0;
					captured_len_q <= '0;
					overflow_q     <= 1'b0;
				end
				MODE_ACK: begin
					change_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (status.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload: flags as they stand after this item's update.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_sel_q                <= rd_en;
			status_q.echo_valid     <= scan || cap;
			status_q.echo_byte      <= (scan || cap) ? c.rx_byte : 8'd0;
			status_q.wifi_up        <= (c.mode == MODE_RX) ? link_d : link_q;
			status_q.socket_up      <= (c.mode == MODE_RX) ? sock_d : sock_q;
			status_q.status_changed <= (c.mode == MODE_ACK) ? 1'b0
				: (change_q || got_hit || disc_hit || conn_hit || closed_hit);
			status_q.payload_ready  <= (c.mode == MODE_RELEASE) ? 1'b0
				: (ready_q || stop_hit);
			status_q.payload_length <= (c.mode == MODE_RELEASE) ? 9'd0
				: (stop_hit ? 9'(captured_val) : (ready_q ? 9'(captured_len_q) : 9'd0));
			status_q.read_data      <= 8'd0;
			status_q.overflow       <= (c.mode == MODE_RELEASE) ? 1'b0
				: (overflow_q || (cap && !room));
		end
	end

	always_comb begin
		status.data           = status_q;
		status.data.read_data = rd_sel_q ? rd_data : 8'd0;
	end
	assign status.valid = out_valid_q;

	`MSP_ASSERT_IMPLY(a_sock_needs_link, clk, arst_n, sock_q, link_q, "socket up while link down")
	`MSP_ASSERT_IMPLY(a_len_clear_idle, clk, arst_n, !ready_q, captured_len_q == '0, "length kept without payload")
	`MSP_ASSERT_IMPLY(a_count_bound, clk, arst_n, 1'b1, wc_q <= CW'(STORE_DEPTH), "write count past store depth")
	`MSP_ASSERT_NEXT(a_ready_holds_store, clk, arst_n, ready_q && !(accept && (c.mode == MODE_RELEASE)), ready_q && (wc_q == '0), "payload lost without release")
endmodule
